// ===== rtl/core/isotp_pkg.sv =====
// shared types, codes and constants of the iso-tp transmit segmenter
package isotp_pkg;

    // payload store depth and address width
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // message length limits
    localparam int MAX_MSG = 4095;
    localparam logic [11:0] LOAD_LIMIT = 12'((STORE_DEPTH < MAX_MSG) ? STORE_DEPTH : MAX_MSG);

    // protocol control nibbles and flow control codes
    localparam logic [3:0] PCI_FIRST    = 4'h1;
    localparam logic [3:0] PCI_CONSEC   = 4'h2;
    localparam logic [7:0] FC_CONTINUE  = 8'h30;
    localparam logic [7:0] FC_OVERFLOW  = 8'h32;
    localparam logic [3:0] FC_LENGTH    = 4'd3;
    localparam logic [3:0] FULL_PAYLOAD = 4'd7;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_FC      = 2'd1,
        KIND_NEXT    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_FRAME   = 2'd0,
        STAT_REJECT  = 2'd1,
        STAT_NOFRAME = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_READY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        FR_NONE,
        FR_REJECT,
        FR_NOFRAME,
        FR_SINGLE,
        FR_FIRST,
        FR_CONSEC
    } frame_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_GATHER,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic      capture;
        logic      load_byte;
        logic      clear_msg;
        logic      start_first;
        logic      fc_continue;
        logic      go_idle;
        logic      cf_advance;
        frame_op_t frame_op;
        logic      out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t      kind;
        logic       last;
        phase_t     phase;
        logic       ovf_new;
        logic       len_small;
        logic       fc_len_ok;
        logic [7:0] fc_status;
        logic       rem_full;
        logic       gather_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/isotp_segmenting_sender_core.sv =====
// top level of the iso-tp transmit segmenter
//
// Usage: the slave stream carries one item per transaction; tuser is the kind
// (payload byte, flow control received, next frame request), tlast marks the
// final payload byte. Payload bytes are stored; a complete message of 1 to 7
// bytes leaves as a single frame, a longer one as a first frame, and each next
// frame request after a continue flow control yields one consecutive frame.
// The master stream carries one result per transaction: tuser is the status,
// tdata the identifier, length and eight frame bytes.
// The configuration channel writes the transmit identifier; it is always ready.
// An item without a result passes the decide state and frees the input on the
// return to idle. A result without store reads (reject, no frame) passes the
// decide, gather and output states; a frame also reads its bytes from the
// payload store (up to 7) in turn through the single read port of the store.
// One item is processed at a time; the next is accepted in the cycle after
// the current one has been handed to the output register.
// Reset clears the protocol state and the output valid flag; the payload store
// is not cleared. When the receiver stalls, the result waits in the output
// register and one further item can be processed up to its own result.
module isotp_segmenting_sender_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,     // tx_can_id
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // data_byte, fc_length, fc_status, fc_block_size,
                                      // fc_separation, zero fill
    input  logic [1:0]  s_tuser,      // kind
    input  logic        s_tlast,      // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,      // can_id, frame_length, byte0 .. byte7, zero fill
    output logic [1:0]  m_tuser       // status
);
    import isotp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    isotp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and frame building
    isotp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== rtl/core/isotp_ctrl.sv =====
// sequencing state machine of the iso-tp transmit segmenter
module isotp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  isotp_pkg::dp_stat_t stat,
    output isotp_pkg::dp_cmd_t  cmd
);
    import isotp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd.frame_op != FR_NONE)
                begin
                    state_next = ST_GATHER;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GATHER:
            begin
                if (stat.gather_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command decode
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECIDE:
            begin
                unique case (stat.kind)
                    KIND_PAYLOAD:
                    begin
                        if (stat.phase != PH_IDLE)
                        begin
                            if (stat.last)
                            begin
                                cmd.frame_op = FR_REJECT;
                            end
                        end
                        else
                        begin
                            cmd.load_byte = 1'b1;
                            if (stat.last)
                            begin
                                if (stat.ovf_new)
                                begin
                                    cmd.clear_msg = 1'b1;
                                    cmd.frame_op  = FR_REJECT;
                                end
                                else if (stat.len_small)
                                begin
                                    cmd.clear_msg = 1'b1;
                                    cmd.frame_op  = FR_SINGLE;
                                end
                                else
                                begin
                                    cmd.start_first = 1'b1;
                                    cmd.frame_op    = FR_FIRST;
                                end
                            end
                        end
                    end
                    KIND_FC:
                    begin
                        if (stat.fc_len_ok && stat.phase == PH_WAIT)
                        begin
                            if (stat.fc_status == FC_CONTINUE)
                            begin
                                cmd.fc_continue = 1'b1;
                            end
                            else if (stat.fc_status == FC_OVERFLOW)
                            begin
                                cmd.go_idle = 1'b1;
                            end
                        end
                    end
                    KIND_NEXT:
                    begin
                        if (stat.phase != PH_READY)
                        begin
                            cmd.frame_op = FR_NOFRAME;
                        end
                        else
                        begin
                            cmd.frame_op = FR_CONSEC;
                            if (stat.rem_full)
                            begin
                                cmd.cf_advance = 1'b1;
                            end
                            else
                            begin
                                cmd.go_idle = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_GATHER:
            begin
            end
            ST_OUT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/isotp_dp.sv =====
// datapath of the iso-tp transmit segmenter: store, counters, frame build, output register
module isotp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [10:0]         cfg_data,
    input  logic [39:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,
    output logic [1:0]          m_tuser,
    input  isotp_pkg::dp_cmd_t  cmd,
    output isotp_pkg::dp_stat_t stat
);
    import isotp_pkg::*;

    // captured input item
    kind_t      itm_kind_reg;
    logic       itm_last_reg;
    logic [7:0] itm_data_reg;
    logic [3:0] itm_fc_len_reg;
    logic [7:0] itm_fc_status_reg;
    logic [7:0] itm_fc_bs_reg;
    logic [7:0] itm_fc_sep_reg;

    // protocol state
    logic [10:0] can_id_reg;
    phase_t      phase_reg;
    logic [11:0] len_reg;
    logic        ovf_reg;
    logic [11:0] offset_reg;
    logic [3:0]  seq_reg;
    logic [7:0]  blk_reg;
    logic [7:0]  sep_reg;

    // payload store
    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    // gather sequencer
    logic [11:0] gth_addr_reg;
    logic [2:0]  gth_slot_reg;
    logic [2:0]  gth_left_reg;
    logic        cap_vld_reg;
    logic [2:0]  cap_slot_reg;

    // frame under construction
    status_t    frm_status_reg;
    logic [3:0] frm_len_reg;
    logic [7:0] frm_byte_reg [8];

    // output register
    logic        out_vld_reg;
    logic [79:0] out_data_reg;
    logic [1:0]  out_user_reg;

    logic        below_limit;
    logic [11:0] len_new;
    logic [11:0] remaining;
    logic        rem_full;
    logic [2:0]  cf_count;
    logic        out_free;
    logic [10:0] out_can_id;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // length after loading the captured byte
    assign below_limit = (len_reg < LOAD_LIMIT);
    assign len_new     = below_limit ? (len_reg + 12'd1) : len_reg;

    // bytes still to send
    assign remaining = (len_reg > offset_reg) ? (len_reg - offset_reg) : 12'd0;
    assign rem_full  = (remaining >= 12'd8);
    assign cf_count  = rem_full ? FULL_PAYLOAD[2:0] : remaining[2:0];

    assign out_free = !out_vld_reg || m_tready;

    // status toward the controller
    always_comb
    begin
        stat.kind        = itm_kind_reg;
        stat.last        = itm_last_reg;
        stat.phase       = phase_reg;
        stat.ovf_new     = ovf_reg || !below_limit;
        stat.len_small   = (len_new <= 12'd7);
        stat.fc_len_ok   = (itm_fc_len_reg == FC_LENGTH);
        stat.fc_status   = itm_fc_status_reg;
        stat.rem_full    = rem_full;
        stat.gather_done = (gth_left_reg == 3'd0) && !cap_vld_reg;
        stat.out_free    = out_free;
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            itm_kind_reg      <= kind_t'(s_tuser);
            itm_last_reg      <= s_tlast;
            itm_data_reg      <= s_tdata[7:0];
            itm_fc_len_reg    <= s_tdata[11:8];
            itm_fc_status_reg <= s_tdata[19:12];
            itm_fc_bs_reg     <= s_tdata[27:20];
            itm_fc_sep_reg    <= s_tdata[35:28];
        end
    end

    // identifier register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_id_reg <= '0;
        end
        else if (cfg_valid)
        begin
            can_id_reg <= cfg_data;
        end
    end

    // protocol state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            offset_reg <= '0;
            seq_reg    <= '0;
            blk_reg    <= '0;
            sep_reg    <= '0;
        end
        else
        begin
            if (cmd.load_byte)
            begin
                len_reg <= len_new;
                if (!below_limit)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.clear_msg)
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.start_first)
            begin
                offset_reg <= 12'd6;
                seq_reg    <= 4'd1;
                phase_reg  <= PH_WAIT;
            end
            if (cmd.fc_continue)
            begin
                blk_reg   <= itm_fc_bs_reg;
                sep_reg   <= itm_fc_sep_reg;
                phase_reg <= PH_READY;
            end
            if (cmd.cf_advance)
            begin
                offset_reg <= offset_reg + 12'd7;
                seq_reg    <= seq_reg + 4'd1;
                if (blk_reg != 8'd0)
                begin
                    blk_reg <= blk_reg - 8'd1;
                    if (blk_reg == 8'd1)
                    begin
                        phase_reg <= PH_WAIT;
                    end
                end
            end
            if (cmd.go_idle)
            begin
                phase_reg  <= PH_IDLE;
                len_reg    <= '0;
                ovf_reg    <= 1'b0;
                offset_reg <= '0;
                seq_reg    <= '0;
                blk_reg    <= '0;
                sep_reg    <= '0;
            end
        end
    end

    // payload store: write on load, registered read during gather
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte && below_limit)
        begin
            mem[len_reg[STORE_AW-1:0]] <= itm_data_reg;
        end
        if (gth_left_reg != 3'd0)
        begin
            rdata_reg <= mem[gth_addr_reg[STORE_AW-1:0]];
        end
    end

    // gather sequencer: one store read per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gth_left_reg <= '0;
            cap_vld_reg  <= 1'b0;
        end
        else
        begin
            cap_vld_reg <= (gth_left_reg != 3'd0);
            if (gth_left_reg != 3'd0)
            begin
                gth_left_reg <= gth_left_reg - 3'd1;
            end
            unique case (cmd.frame_op)
                FR_SINGLE:  gth_left_reg <= len_new[2:0];
                FR_FIRST:   gth_left_reg <= 3'd6;
                FR_CONSEC:  gth_left_reg <= cf_count;
                default:
                begin
                end
            endcase
        end
    end

    // gather addressing
    always_ff @(posedge clk)
    begin
        cap_slot_reg <= gth_slot_reg;
        if (gth_left_reg != 3'd0)
        begin
            gth_addr_reg <= gth_addr_reg + 12'd1;
            gth_slot_reg <= gth_slot_reg + 3'd1;
        end
        unique case (cmd.frame_op)
            FR_SINGLE:
            begin
                gth_addr_reg <= '0;
                gth_slot_reg <= 3'd1;
            end
            FR_FIRST:
            begin
                gth_addr_reg <= '0;
                gth_slot_reg <= 3'd2;
            end
            FR_CONSEC:
            begin
                gth_addr_reg <= offset_reg;
                gth_slot_reg <= 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // frame header setup and data fill
    always_ff @(posedge clk)
    begin
        if (cap_vld_reg)
        begin
            frm_byte_reg[cap_slot_reg] <= rdata_reg;
        end
        if (cmd.frame_op != FR_NONE)
        begin
            for (int i = 0; i < 8; i++)
            begin
                frm_byte_reg[i] <= '0;
            end
            frm_status_reg <= STAT_FRAME;
            frm_len_reg    <= '0;
        end
        unique case (cmd.frame_op)
            FR_REJECT:
            begin
                frm_status_reg <= STAT_REJECT;
            end
            FR_NOFRAME:
            begin
                frm_status_reg <= STAT_NOFRAME;
            end
            FR_SINGLE:
            begin
                frm_byte_reg[0] <= {4'h0, len_new[3:0]};
                frm_len_reg     <= len_new[3:0] + 4'd1;
            end
            FR_FIRST:
            begin
                frm_byte_reg[0] <= {PCI_FIRST, len_new[11:8]};
                frm_byte_reg[1] <= len_new[7:0];
                frm_len_reg     <= 4'd8;
            end
            FR_CONSEC:
            begin
                frm_byte_reg[0] <= {PCI_CONSEC, seq_reg};
                frm_len_reg     <= {1'b0, cf_count} + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    // identifier only on emitted frames
    assign out_can_id = (frm_status_reg == STAT_FRAME) ? can_id_reg : 11'd0;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_user_reg <= frm_status_reg;
            out_data_reg <= {1'b0,
                             frm_byte_reg[7], frm_byte_reg[6], frm_byte_reg[5],
                             frm_byte_reg[4], frm_byte_reg[3], frm_byte_reg[2],
                             frm_byte_reg[1], frm_byte_reg[0],
                             frm_len_reg, out_can_id};
        end
    end

endmodule
